@@ design/crlfg_pkg.sv @@
// crlfg_pkg: shared types, character codes and helpers for the crlf translator with flow gate
// used by crlfg_core, crlfg_resq and crlf_translator_with_flow_gate_top
// no dependencies
package crlfg_pkg;

  // character codes
  localparam logic [7:0] ChLf   = 8'h0a;
  localparam logic [7:0] ChCr   = 8'h0d;
  localparam logic [7:0] ChXoff = 8'h13;
  localparam logic [7:0] ChXon  = 8'h11;

  // payload widths
  localparam int unsigned InDataW  = 16;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned PauseW   = 10;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 3;
  localparam int unsigned QDepth   = 3;
  localparam int unsigned QCntW    = 2;

  typedef enum logic [1:0] {
    OpHostTx = 2'd0,
    OpLineRx = 2'd1,
    OpHshake = 2'd2,
    OpRsvd   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CfgFlowMask = 2'd0,
    CfgCrlfMode = 2'd1,
    CfgCrDelay  = 2'd2,
    CfgNone     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ModeOff     = 2'd0,
    ModeLfToCr  = 2'd1,
    ModeCrLfCr  = 2'd2,
    ModeLfCrLf  = 2'd3
  } crlf_mode_e;

  // flow mask bit positions
  localparam int unsigned FlowRtsBit = 0;
  localparam int unsigned FlowDtrBit = 1;
  localparam int unsigned FlowXonBit = 2;

  typedef struct packed {
    logic [PauseW-1:0] pause_ms;
    logic [7:0]        host_byte;
    logic              host_valid;
    logic [7:0]        line_byte;
    logic              line_valid;
    logic              accepted;
    logic              last;
  } res_t;

  typedef struct packed {
    logic cr_seen;
    logic xoff_active;
    logic rts_level;
    logic dtr_level;
  } flow_st_t;

  localparam res_t ResNone = '{default: '0};

  // pause after a sent cr: 5 << code ms, none for code 0
  function automatic logic [PauseW-1:0] cr_pause(input logic [2:0] code);
    logic [PauseW-1:0] five;
    five = PauseW'(5);
    if (code == 3'd0) begin
      return '0;
    end
    return five << code;
  endfunction

endpackage

@@ design/crlf_translator_with_flow_gate_top.sv @@
// crlf_translator_with_flow_gate_top: top level of the crlf translator with flow gate
// depends on crlfg_pkg, crlfg_core and crlfg_resq
//
// Takes one word per clock cycle on the slave stream, while it is ready, and answers each
// with one or two result words on the master stream, in order, with tlast on the final
// one. A word is translated in the cycle it is accepted, against the flow and line-ending
// state left by the word before, and its results go into a three-slot result queue; the
// master side reads the queue head. The slave side is ready whenever the queue has two free
// slots, so with the master side taking every word the block runs at one word per cycle,
// and a result word is registered in the queue before it is visible on the master side.
// Only the expanded line end (mode 3, a cr going out) yields two words; a burst of those
// is slowed by the single queue read port. Configuration writes take effect on the next
// edge and are expected while no word is in flight.
module crlf_translator_with_flow_gate_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [crlfg_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [crlfg_pkg::CfgDataW-1:0]     cfg_data_i,
  // slave stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata: data_byte[7:0], partner_rts[8], partner_dtr[9], zero fill
  input  logic [crlfg_pkg::InDataW-1:0]      s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [crlfg_pkg::InUserW-1:0]      s_axis_tuser,
  // master stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata: accepted[0], line_valid[1], line_byte[9:2], host_valid[10],
  //        host_byte[18:11], pause_ms[28:19], zero fill
  output logic [crlfg_pkg::OutDataW-1:0]     m_axis_tdata,
  output logic                               m_axis_tlast
);

  logic                          s_fire;
  logic                          m_fire;
  crlfg_pkg::res_t               res0, res1, head;
  logic                          two;
  logic [crlfg_pkg::QCntW-1:0]   q_cnt;
  crlfg_pkg::flow_st_t           st;

  // room for the worst case of two results
  assign s_axis_tready = (q_cnt <= crlfg_pkg::QCntW'(1));
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (q_cnt != '0);
  assign m_fire        = m_axis_tvalid && m_axis_tready;

  crlfg_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .fire_i     (s_fire),
    .op_i       (crlfg_pkg::op_e'(s_axis_tuser)),
    .byte_i     (s_axis_tdata[7:0]),
    .rts_i      (s_axis_tdata[8]),
    .dtr_i      (s_axis_tdata[9]),
    .res0_o     (res0),
    .res1_o     (res1),
    .two_o      (two),
    .st_o       (st)
  );

  crlfg_resq u_resq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_fire),
    .two_i  (two),
    .res0_i (res0),
    .res1_i (res1),
    .pop_i  (m_fire),
    .head_o (head),
    .cnt_o  (q_cnt)
  );

  // pack the result word, highest field first
  assign m_axis_tdata = {3'b000, head.pause_ms, head.host_byte, head.host_valid,
                         head.line_byte, head.line_valid, head.accepted};
  assign m_axis_tlast = head.last;

  // queue never overfills
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt != crlfg_pkg::QCntW'(3) || !s_axis_tready)
    else $error("result queue full while ready");

  // a gated host word leaves all flow state untouched
  a_gate_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !res0.accepted && !res0.line_valid |=> $stable(st))
    else $error("flow state moved on a gated host word");

  // a two-word result is never left with lf pending
  a_crlf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && two |=> !st.cr_seen)
    else $error("cr_seen left set after expanded line end");

endmodule

@@ design/crlfg_core.sv @@
// crlfg_core: configuration registers, flow state and the per-word translation logic
// depends on crlfg_pkg
module crlfg_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [crlfg_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [crlfg_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                              fire_i,
  input  crlfg_pkg::op_e                    op_i,
  input  logic [7:0]                        byte_i,
  input  logic                              rts_i,
  input  logic                              dtr_i,
  output crlfg_pkg::res_t                   res0_o,
  output crlfg_pkg::res_t                   res1_o,
  output logic                              two_o,
  output crlfg_pkg::flow_st_t               st_o
);

  logic [2:0] flow_mask_q;
  logic [1:0] crlf_mode_q;
  logic [2:0] cr_delay_q;

  crlfg_pkg::flow_st_t st_q, st_d;
  crlfg_pkg::res_t     res0, res1;
  logic                two;
  logic [2:0]          stops;
  logic [7:0]          tx_byte;
  logic                tx_is_cr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_mask_q <= '0;
      crlf_mode_q <= '0;
      cr_delay_q  <= '0;
    end else if (cfg_we_i) begin
      case (crlfg_pkg::cfg_idx_e'(cfg_idx_i))
        crlfg_pkg::CfgFlowMask: flow_mask_q <= cfg_data_i;
        crlfg_pkg::CfgCrlfMode: crlf_mode_q <= cfg_data_i[1:0];
        crlfg_pkg::CfgCrDelay:  cr_delay_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d  = st_q;
    res0  = crlfg_pkg::ResNone;
    res1  = crlfg_pkg::ResNone;
    two   = 1'b0;
    stops = {st_q.xoff_active, st_q.dtr_level, st_q.rts_level};
    // lf becomes cr in the two cr-producing modes
    tx_byte = (crlf_mode_q[0] && byte_i == crlfg_pkg::ChLf) ? crlfg_pkg::ChCr : byte_i;
    tx_is_cr = (tx_byte == crlfg_pkg::ChCr);
    res0.last     = 1'b1;
    res0.accepted = 1'b1;

    case (op_i)
      crlfg_pkg::OpHostTx: begin
        if ((flow_mask_q & stops) != 3'd0) begin
          res0.accepted = 1'b0;
        end else if (st_q.cr_seen && crlf_mode_q == crlfg_pkg::ModeLfCrLf) begin
          // owed lf, host word to be offered again
          st_d.cr_seen    = 1'b0;
          res0.accepted   = 1'b0;
          res0.line_valid = 1'b1;
          res0.line_byte  = crlfg_pkg::ChLf;
        end else if (st_q.cr_seen && crlf_mode_q == crlfg_pkg::ModeCrLfCr &&
                     (byte_i == crlfg_pkg::ChLf || byte_i == crlfg_pkg::ChCr)) begin
          st_d.cr_seen = (byte_i == crlfg_pkg::ChCr);
        end else if (tx_is_cr && crlf_mode_q == crlfg_pkg::ModeLfCrLf) begin
          st_d.cr_seen    = 1'b0;
          two             = 1'b1;
          res0.last       = 1'b0;
          res0.line_valid = 1'b1;
          res0.line_byte  = crlfg_pkg::ChCr;
          res0.pause_ms   = crlfg_pkg::cr_pause(cr_delay_q);
          res1.accepted   = 1'b1;
          res1.last       = 1'b1;
          res1.line_valid = 1'b1;
          res1.line_byte  = crlfg_pkg::ChLf;
        end else begin
          st_d.cr_seen    = tx_is_cr;
          res0.line_valid = 1'b1;
          res0.line_byte  = tx_byte;
          res0.pause_ms   = tx_is_cr ? crlfg_pkg::cr_pause(cr_delay_q) : '0;
        end
      end
      crlfg_pkg::OpLineRx: begin
        if (flow_mask_q[crlfg_pkg::FlowXonBit] && byte_i == crlfg_pkg::ChXoff) begin
          st_d.xoff_active = 1'b1;
        end else if (flow_mask_q[crlfg_pkg::FlowXonBit] && byte_i == crlfg_pkg::ChXon) begin
          st_d.xoff_active = 1'b0;
        end else begin
          res0.host_valid = 1'b1;
          res0.host_byte  = byte_i;
        end
      end
      crlfg_pkg::OpHshake: begin
        st_d.rts_level = rts_i;
        st_d.dtr_level = dtr_i;
      end
      default: ;
    endcase
  end

  assign res0_o = res0;
  assign res1_o = res1;
  assign two_o  = two;
  assign st_o   = st_q;

endmodule

@@ design/crlfg_resq.sv @@
// crlfg_resq: three-slot shifting result queue, takes one or two results per word
// depends on crlfg_pkg
module crlfg_resq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          two_i,
  input  crlfg_pkg::res_t               res0_i,
  input  crlfg_pkg::res_t               res1_i,
  input  logic                          pop_i,
  output crlfg_pkg::res_t               head_o,
  output logic [crlfg_pkg::QCntW-1:0]   cnt_o
);

  crlfg_pkg::res_t               slot_q [crlfg_pkg::QDepth];
  crlfg_pkg::res_t               slot_d [crlfg_pkg::QDepth];
  logic [crlfg_pkg::QCntW-1:0]   cnt_q, cnt_d, rem;
  logic                          do_pop;

  always_comb begin
    do_pop = pop_i && (cnt_q != '0);
    rem    = cnt_q - crlfg_pkg::QCntW'(do_pop);
    for (int i = 0; i < crlfg_pkg::QDepth; i++) begin
      if (do_pop && i < crlfg_pkg::QDepth - 1) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if (push_i && crlfg_pkg::QCntW'(i) == rem) begin
        slot_d[i] = res0_i;
      end
      if (push_i && two_i && crlfg_pkg::QCntW'(i) == rem + 2'd1) begin
        slot_d[i] = res1_i;
      end
    end
    cnt_d = rem + (push_i ? (two_i ? 2'd2 : 2'd1) : 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // payload slots, no reset
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < crlfg_pkg::QDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

  assign head_o = slot_q[0];
  assign cnt_o  = cnt_q;

endmodule
